// ===== rtl/core/vmt_pkg.sv =====
// shared types and constants for the vec4 matrix transform
// no dependencies
package vmt_pkg;

    localparam int unsigned NUM_PAIRS = 8;
    localparam int unsigned QBITS     = 33;

    typedef struct packed {
        logic        op;
        logic [31:0] in_x;
        logic [31:0] in_y;
        logic [31:0] in_z;
        logic [31:0] in_w;
    } t_req;

    typedef struct packed {
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [31:0] out_z;
        logic [31:0] out_w;
        logic        valid_res;
        logic        saturated;
    } t_rsp;

    // sixteen column-major entries
    typedef logic [15:0][31:0] t_mat;

    // transform stage output, r[3] is w
    typedef struct packed {
        logic             op;
        logic             sat;
        logic [3:0][31:0] r;
    } t_tx;

    localparam logic OP_XFORM = 1'b0;
    localparam logic OP_PDIV  = 1'b1;

endpackage

// ===== rtl/core/vec4_matrix_transform_project.sv =====
// top level: matrix registers on the apb port, transform pipeline, divide pipeline
// depends on vmt_pkg, vmt_mac, vmt_div
//
// channel   direction  handshake                      payload
// request   in         start high, busy low           i_req (t_req)
// result    out        o_res_valid, one cycle strobe  o_res (t_rsp)
// config    in         apb write, pready always high  pwdata, 8 x 64-bit pairs
//
// a request enters every cycle; busy is never raised
// three multiply/accumulate/saturate stages, then a prep stage,
// 33 restoring divide stages (one quotient bit each) and an output stage
// plain transforms ride the divide pipeline too, so every op has the same latency
// synchronous active-low reset empties the pipeline and loads the identity matrix
// the receiver cannot stall, so results leave on a fixed schedule
module vec4_matrix_transform_project #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  vmt_pkg::t_req i_req,
    output logic          o_res_valid,
    output vmt_pkg::t_rsp o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [5:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    import vmt_pkg::*;

    localparam int LAT = 3 + QBITS + 2;
    localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

    logic [63:0] r_pair [NUM_PAIRS];
    t_mat        mat;
    logic        mac_vld;
    t_tx         mac_tx;
    logic        req_take;
    logic        cfg_wr;

    // pipeline never holds a request off
    assign busy     = 1'b0;
    assign req_take = start & ~busy;
    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;

    // matrix register file, identity at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_PAIRS; k++) begin
                r_pair[k] <= '0;
            end
            r_pair[0] <= ONE;
            r_pair[2] <= ONE << 32;
            r_pair[5] <= ONE;
            r_pair[7] <= ONE << 32;
        end else if (cfg_wr) begin
            r_pair[paddr[5:3]] <= pwdata;
        end
    end

    assign prdata = r_pair[paddr[5:3]];

    // entry 2k in the low half, 2k+1 in the high half
    always_comb begin
        for (int k = 0; k < NUM_PAIRS; k++) begin
            mat[2*k]   = r_pair[k][31:0];
            mat[2*k+1] = r_pair[k][63:32];
        end
    end

    vmt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (req_take),
        .i_req   (i_req),
        .i_mat   (mat),
        .o_vld   (mac_vld),
        .o_tx    (mac_tx)
    );

    vmt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (mac_vld),
        .i_tx    (mac_tx),
        .o_vld   (o_res_valid),
        .o_res   (o_res)
    );

    // every request yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |-> ##LAT o_res_valid)
        else $error("result missing after request");

    // a zero divisor clears all components
    a_zero_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.valid_res) |->
            (o_res.out_x == '0 && o_res.out_y == '0 && o_res.out_z == '0
             && o_res.out_w == '0))
        else $error("invalid result with nonzero components");

    // pipeline is empty on the first cycle out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_res_valid)
        else $error("result strobe right after reset");

endmodule

// ===== rtl/core/vmt_mac.sv =====
// multiply-accumulate, round and saturate: three register stages
// depends on vmt_pkg
module vmt_mac #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  vmt_pkg::t_req i_req,
    input  vmt_pkg::t_mat i_mat,
    output logic          o_vld,
    output vmt_pkg::t_tx  o_tx
);
    import vmt_pkg::*;

    localparam int SW = 67;
    localparam logic signed [SW-1:0] ROUND = SW'(1) << (FRAC_BITS - 1);

    logic signed [31:0] v [4];
    logic signed [31:0] m [16];
    logic signed [63:0] n_prod [4][4];
    logic signed [63:0] r_prod [4][4];
    logic signed [SW-1:0] n_sum [4];
    logic signed [SW-1:0] r_sum [4];
    logic signed [SW-1:0] sh [4];
    logic [3:0][31:0] n_r;
    logic [3:0]       n_sat;
    logic r_v1, r_v2, r_v3;
    logic r_op1, r_op2;
    logic [3:0][31:0] r_r;
    logic r_sat, r_op3;

    always_comb begin
        v[0] = i_req.in_x;
        v[1] = i_req.in_y;
        v[2] = i_req.in_z;
        v[3] = i_req.in_w;
        for (int k = 0; k < 16; k++) begin
            m[k] = i_mat[k];
        end
        for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
                n_prod[row][col] = v[col] * m[col*4 + row];
            end
        end
    end

    always_comb begin
        for (int row = 0; row < 4; row++) begin
            n_sum[row] = SW'(r_prod[row][0]) + SW'(r_prod[row][1])
                       + SW'(r_prod[row][2]) + SW'(r_prod[row][3]) + ROUND;
        end
    end

    // drop fraction, clamp to 32-bit signed
    always_comb begin
        for (int row = 0; row < 4; row++) begin
            sh[row] = r_sum[row] >>> FRAC_BITS;
            if (sh[row][SW-1:31] == {(SW-31){sh[row][31]}}) begin
                n_r[row]   = sh[row][31:0];
                n_sat[row] = 1'b0;
            end else begin
                n_r[row]   = sh[row][SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                n_sat[row] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_prod <= n_prod;
        r_op1  <= i_req.op;
        r_sum  <= n_sum;
        r_op2  <= r_op1;
        r_r    <= n_r;
        r_sat  <= |n_sat;
        r_op3  <= r_op2;
    end

    assign o_vld    = r_v3;
    assign o_tx.op  = r_op3;
    assign o_tx.sat = r_sat;
    assign o_tx.r   = r_r;

endmodule

// ===== rtl/core/vmt_div.sv =====
// perspective divide: prep stage, one quotient bit per stage, output stage
// depends on vmt_pkg
module vmt_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  vmt_pkg::t_tx  i_tx,
    output logic          o_vld,
    output vmt_pkg::t_rsp o_res
);
    import vmt_pkg::*;

    localparam int DW = 33 + FRAC_BITS;
    localparam int RW = 34;

    // prep
    logic [31:0]    p_aw;
    logic [31:0]    p_ac [3];
    logic [DW-1:0]  p_d  [3];
    logic [2:0]     p_neg, p_ovf;

    // per-stage registers, index 0 is the prep stage
    logic            r_vld  [QBITS+1];
    t_tx             r_tx   [QBITS+1];
    logic [31:0]     r_aw   [QBITS+1];
    logic [2:0]      r_neg  [QBITS+1];
    logic [2:0]      r_ovf  [QBITS+1];
    logic [RW-1:0]   r_rem  [QBITS+1][3];
    logic [QBITS-1:0] r_low [QBITS+1][3];
    logic [QBITS-1:0] r_q   [QBITS+1][3];

    logic [RW-1:0]    n_rem [QBITS+1][3];
    logic [QBITS-1:0] n_q   [QBITS+1][3];
    logic [RW-1:0]    t_try [QBITS+1][3];

    logic [31:0] f_q  [3];
    logic [2:0]  f_sat;
    t_rsp        n_res;
    t_rsp        r_res;
    logic        r_out_vld;
    logic        zero_w;

    always_comb begin
        p_aw = i_tx.r[3][31] ? (~i_tx.r[3] + 32'd1) : i_tx.r[3];
        for (int l = 0; l < 3; l++) begin
            p_ac[l]  = i_tx.r[l][31] ? (~i_tx.r[l] + 32'd1) : i_tx.r[l];
            p_d[l]   = DW'({p_ac[l], {FRAC_BITS{1'b0}}}) + DW'(p_aw >> 1);
            p_neg[l] = i_tx.r[l][31] ^ i_tx.r[3][31];
            p_ovf[l] = RW'(p_d[l][DW-1:QBITS]) >= RW'(p_aw);
        end
    end

    // restoring step
    always_comb begin
        for (int s = 0; s <= QBITS; s++) begin
            for (int l = 0; l < 3; l++) begin
                t_try[s][l] = '0;
                n_rem[s][l] = '0;
                n_q[s][l]   = '0;
            end
        end
        for (int s = 1; s <= QBITS; s++) begin
            for (int l = 0; l < 3; l++) begin
                t_try[s][l] = {r_rem[s-1][l][RW-2:0], r_low[s-1][l][QBITS-1]};
                if (t_try[s][l] >= RW'(r_aw[s-1])) begin
                    n_rem[s][l] = t_try[s][l] - RW'(r_aw[s-1]);
                    n_q[s][l]   = {r_q[s-1][l][QBITS-2:0], 1'b1};
                end else begin
                    n_rem[s][l] = t_try[s][l];
                    n_q[s][l]   = {r_q[s-1][l][QBITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QBITS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int s = 1; s <= QBITS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
        r_tx[0]  <= i_tx;
        r_aw[0]  <= p_aw;
        r_neg[0] <= p_neg;
        r_ovf[0] <= p_ovf;
        for (int l = 0; l < 3; l++) begin
            r_rem[0][l] <= RW'(p_d[l][DW-1:QBITS]);
            r_low[0][l] <= p_d[l][QBITS-1:0];
            r_q[0][l]   <= '0;
        end
        for (int s = 1; s <= QBITS; s++) begin
            r_tx[s]  <= r_tx[s-1];
            r_aw[s]  <= r_aw[s-1];
            r_neg[s] <= r_neg[s-1];
            r_ovf[s] <= r_ovf[s-1];
            for (int l = 0; l < 3; l++) begin
                r_rem[s][l] <= n_rem[s][l];
                r_low[s][l] <= {r_low[s-1][l][QBITS-2:0], 1'b0};
                r_q[s][l]   <= n_q[s][l];
            end
        end
    end

    // sign, clamp and select
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (!r_neg[QBITS][l]) begin
                f_sat[l] = r_ovf[QBITS][l] | (|r_q[QBITS][l][QBITS-1:31]);
                f_q[l]   = f_sat[l] ? 32'h7FFF_FFFF : r_q[QBITS][l][31:0];
            end else begin
                f_sat[l] = r_ovf[QBITS][l] | r_q[QBITS][l][QBITS-1]
                         | (r_q[QBITS][l][31] & (|r_q[QBITS][l][30:0]));
                f_q[l]   = f_sat[l] ? 32'h8000_0000 : (~r_q[QBITS][l][31:0] + 32'd1);
            end
        end
        zero_w          = (r_tx[QBITS].r[3] == 32'd0);
        n_res.out_w     = r_tx[QBITS].r[3];
        n_res.valid_res = 1'b1;
        n_res.saturated = r_tx[QBITS].sat;
        n_res.out_x     = r_tx[QBITS].r[0];
        n_res.out_y     = r_tx[QBITS].r[1];
        n_res.out_z     = r_tx[QBITS].r[2];
        if (r_tx[QBITS].op == OP_PDIV) begin
            if (zero_w) begin
                n_res.valid_res = 1'b0;
                n_res.out_x     = '0;
                n_res.out_y     = '0;
                n_res.out_z     = '0;
            end else begin
                n_res.out_x     = f_q[0];
                n_res.out_y     = f_q[1];
                n_res.out_z     = f_q[2];
                n_res.saturated = r_tx[QBITS].sat | (|f_sat);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[QBITS];
        end
        r_res <= n_res;
    end

    assign o_vld = r_out_vld;
    assign o_res = r_res;

endmodule

// ===== dv/vec4_matrix_transform_project_tb.sv =====
// self-checking testbench for the vec4 matrix transform, request in, one result out
// depends on vmt_pkg and vec4_matrix_transform_project
module vec4_matrix_transform_project_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vmt_pkg::*;

    localparam int FRAC      = 16;
    localparam int PIPE_LAT  = 38;
    localparam int CYC_LIMIT = 400000;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_res_valid;
    t_rsp        o_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    vec4_matrix_transform_project DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_res_valid(o_res_valid), .o_res(o_res), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the matrix registers
    logic [63:0] mat_pair [NUM_PAIRS];
    t_req        pending_reqs [$];
    t_rsp        expected_rsps [$];
    int          sender_idle_pct = 27;
    bit          req_taken = 1'b0;
    int          fail_count = 0;
    int          cycle_count = 0;

    function automatic logic signed [31:0] mat_entry(int idx);
        logic [63:0] pair;
        pair = mat_pair[idx >> 1];
        return (idx & 1) ? pair[63:32] : pair[31:0];
    endfunction

    // round half up, shift out the fraction, clamp to 32 bits
    function automatic logic signed [31:0] round_clamp(logic signed [79:0] acc, ref bit sat);
        logic signed [79:0] sh;
        sh = (acc + (80'sd1 <<< (FRAC - 1))) >>> FRAC;
        if (sh > 80'(Q_MAX)) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (sh < 80'(Q_MIN)) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return sh[31:0];
    endfunction

    // fixed-point quotient, nearest with ties away from zero
    function automatic logic signed [31:0] fx_quotient(logic signed [31:0] c,
                                                       logic signed [31:0] w, ref bit sat);
        logic signed [63:0] num;
        logic [63:0] an, aw, q;
        bit neg;
        num = 64'(c) <<< FRAC;
        an  = num < 0 ? -num : num;
        aw  = w < 0 ? -64'(w) : 64'(w);
        neg = (num < 0) != (w < 0);
        q   = (an + aw / 2) / aw;
        if (!neg && q > 64'h7FFFFFFF) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (neg && q > 64'h80000000) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    function automatic t_rsp transform_vertex(t_req rq);
        logic signed [31:0] v [4];
        logic signed [31:0] r [4];
        logic signed [79:0] acc;
        bit sat;
        bit ok;
        t_rsp rsp;
        sat = 1'b0;
        ok  = 1'b1;
        v[0] = rq.in_x; v[1] = rq.in_y; v[2] = rq.in_z; v[3] = rq.in_w;
        for (int row = 0; row < 4; row++) begin
            acc = '0;
            for (int col = 0; col < 4; col++)
                acc += 80'(v[col]) * 80'(mat_entry(col * 4 + row));
            r[row] = round_clamp(acc, sat);
        end
        if (rq.op == OP_PDIV) begin
            if (r[3] == 0) begin
                // zero divisor: components forced to zero and flagged
                ok = 1'b0;
                r[0] = '0; r[1] = '0; r[2] = '0;
            end else begin
                for (int row = 0; row < 3; row++)
                    r[row] = fx_quotient(r[row], r[3], sat);
            end
        end
        rsp.out_x = r[0]; rsp.out_y = r[1]; rsp.out_z = r[2]; rsp.out_w = r[3];
        rsp.valid_res = ok;
        rsp.saturated = sat;
        return rsp;
    endfunction

    // accept at the rising edge: requests, register writes, results, watchdog
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT) begin
            $display("vec4_matrix_transform_project_tb NOT OK");
            $finish;
        end
        if (i_rst_n) begin
            if (start && !busy) begin
                expected_rsps.push_back(transform_vertex(i_req));
                req_taken = 1'b1;
            end
            if (psel && penable && pwrite && pready && paddr[5:3] < NUM_PAIRS)
                mat_pair[paddr[5:3]] = pwdata;
            if (o_res_valid) begin
                if (expected_rsps.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (o_res.out_x !== exp_rsp.out_x) begin
                        $error("out_x exp %h got %h", exp_rsp.out_x, o_res.out_x);
                        fail_count++;
                    end
                    if (o_res.out_y !== exp_rsp.out_y) begin
                        $error("out_y exp %h got %h", exp_rsp.out_y, o_res.out_y);
                        fail_count++;
                    end
                    if (o_res.out_z !== exp_rsp.out_z) begin
                        $error("out_z exp %h got %h", exp_rsp.out_z, o_res.out_z);
                        fail_count++;
                    end
                    if (o_res.out_w !== exp_rsp.out_w) begin
                        $error("out_w exp %h got %h", exp_rsp.out_w, o_res.out_w);
                        fail_count++;
                    end
                    if (o_res.valid_res !== exp_rsp.valid_res) begin
                        $error("valid_res exp %b got %b", exp_rsp.valid_res, o_res.valid_res);
                        fail_count++;
                    end
                    if (o_res.saturated !== exp_rsp.saturated) begin
                        $error("saturated exp %b got %b", exp_rsp.saturated, o_res.saturated);
                        fail_count++;
                    end
                end
            end
        end
    end

    // request driver: holds a request until taken, idles at random
    always @(negedge i_clk) begin
        if (!start || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                start <= 1'b1;
                i_req <= pending_reqs.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
        req_taken = 1'b0;
    end

    // mixes full-range, small, and extreme component values
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0, 1: return $urandom();
            2, 3: return 32'($signed($urandom_range(8 << FRAC)) - (4 << FRAC));
            4:    return $urandom_range(1) ? Q_MAX : Q_MIN;
            default: return $urandom_range(3) == 0 ? 32'd0 : 32'($signed($urandom_range(64)) - 32);
        endcase
    endfunction

    function automatic t_req make_req(logic op, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, logic [31:0] w);
        t_req rq;
        rq.op = op; rq.in_x = x; rq.in_y = y; rq.in_z = z; rq.in_w = w;
        return rq;
    endfunction

    task automatic write_pair(int idx, logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 6'(idx * 8); pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // waits until every request is sent and every result is back, then lets the pipe drain
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic queue_random(int n);
        repeat (n)
            pending_reqs.push_back(make_req($urandom_range(1), rand_comp(), rand_comp(),
                                            rand_comp(), rand_comp()));
    endtask

    initial begin
        logic [63:0] one_q;
        logic [31:0] e_lo, e_hi;
        one_q = 64'd1 << FRAC;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // identity after reset
        for (int k = 0; k < NUM_PAIRS; k++) mat_pair[k] = '0;
        mat_pair[0] = one_q; mat_pair[2] = one_q << 32;
        mat_pair[5] = one_q; mat_pair[7] = one_q << 32;

        // directed: extremes, both ops, zero w, divide overflow
        pending_reqs.push_back(make_req(OP_XFORM, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_PDIV, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_XFORM, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        pending_reqs.push_back(make_req(OP_XFORM, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        pending_reqs.push_back(make_req(OP_PDIV, Q_MAX, Q_MIN, Q_MAX, Q_MAX));
        pending_reqs.push_back(make_req(OP_PDIV, Q_MIN, Q_MAX, Q_MIN, Q_MIN));
        pending_reqs.push_back(make_req(OP_PDIV, Q_MAX, Q_MIN, 32'd1 << FRAC, 32'd1));
        pending_reqs.push_back(make_req(OP_PDIV, Q_MIN, Q_MAX, 32'd5, -32'sd1));
        pending_reqs.push_back(make_req(OP_PDIV, 32'd3 << FRAC, -32'sd7, 1, 32'd2 << FRAC));
        pending_reqs.push_back(make_req(OP_PDIV, 32'd1, -32'sd1, 32'd3, 32'd2 << FRAC));
        pending_reqs.push_back(make_req(OP_PDIV, 32'h12345678, 32'hFFFFFFFF, 0, 32'd0));
        pending_reqs.push_back(make_req(OP_XFORM, -32'sd1, 32'h5555AAAA, 32'hAAAA5555, 1));
        queue_random(140);
        wait_drained();

        // large random matrix, saturation likely
        for (int k = 0; k < NUM_PAIRS; k++) write_pair(k, {$urandom(), $urandom()});
        queue_random(150);
        wait_drained();

        sender_idle_pct = 50;
        // modest entries, perspective-like
        for (int k = 0; k < NUM_PAIRS; k++) begin
            e_lo = 32'($signed($urandom_range(4 << FRAC)) - (2 << FRAC));
            e_hi = 32'($signed($urandom_range(4 << FRAC)) - (2 << FRAC));
            write_pair(k, {e_hi, e_lo});
        end
        queue_random(150);
        wait_drained();

        // extreme entries
        for (int k = 0; k < NUM_PAIRS; k++)
            write_pair(k, k[0] ? {Q_MIN, Q_MAX} : {Q_MAX, Q_MIN});
        queue_random(150);
        wait_drained();

        sender_idle_pct = 0;
        // w row cleared: every divide meets a zero w
        for (int k = 0; k < NUM_PAIRS; k++) write_pair(k, {32'd0, $urandom()});
        queue_random(150);
        wait_drained();

        // all zero, then all ones
        for (int k = 0; k < NUM_PAIRS; k++) write_pair(k, 64'd0);
        queue_random(30);
        wait_drained();
        for (int k = 0; k < NUM_PAIRS; k++) write_pair(k, '1);
        queue_random(120);
        wait_drained();

        if (fail_count == 0)
            $display("vec4_matrix_transform_project_tb OK");
        else
            $display("vec4_matrix_transform_project_tb NOT OK");
        $finish;
    end

endmodule
